// File: rtl/assert_macros.svh
// Assertion macros used by the RTL walker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on aclk, muted while aresetn is low.
`define DND_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Implication form: when the condition holds, the consequence holds too.
`define DND_ASSERT_IMP(lbl, cond, conseq) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (conseq)) \
        else $error("assertion failed");

`endif

// File: rtl/dnd_pkg.sv
// Shared types and constants of the DNS name decompressor.
`timescale 1ns / 1ps

package dnd_pkg;

    localparam int MESSAGE_DEPTH   = 4096;
    localparam int MAX_NAME_LENGTH = 255;
    localparam int MSG_AW          = $clog2(MESSAGE_DEPTH);
    localparam int NAME_AW         = $clog2(MAX_NAME_LENGTH);
    localparam int POS_W           = 15;
    localparam int TOT_W           = 9;
    localparam int LEN_W           = 13;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NAME = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OOB         = 3'd1;
    localparam logic [2:0] ST_BAD_POINTER = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;

    typedef enum logic {
        REQ_LOAD,
        REQ_NAME
    } req_kind_t;

    typedef struct packed {
        logic        operation;
        logic [11:0] offset;
        logic [7:0]  byte_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] name_bytes;
        logic [3:0]  byte_count;
        logic        last;
        logic [2:0]  status;
        logic [7:0]  total_length;
    } out_item_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [11:0] offset;
        logic [7:0]  byte_value;
    } req_t;

endpackage

// File: rtl/dnd_front.sv
// Request intake: classify incoming requests and drop loads outside the store.
`timescale 1ns / 1ps

module dnd_front (
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dnd_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output dnd_pkg::req_t     q_entry
);

    logic load_in_range;
    logic drop;

    assign load_in_range = {1'b0, s_data.offset} < 13'(dnd_pkg::MESSAGE_DEPTH);
    assign drop          = (s_data.operation == dnd_pkg::OP_LOAD) && !load_in_range;

    assign s_ready = !q_full && aresetn;
    assign q_push  = s_valid && s_ready && !drop;

    assign q_entry.kind       = (s_data.operation == dnd_pkg::OP_NAME) ?
                                dnd_pkg::REQ_NAME : dnd_pkg::REQ_LOAD;
    assign q_entry.offset     = s_data.offset;
    assign q_entry.byte_value = s_data.byte_value;

endmodule

// File: rtl/dnd_queue.sv
// Two-entry request queue between intake and the name walker.
`timescale 1ns / 1ps

module dnd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dnd_pkg::req_t push_data,
    output logic          full,
    output logic          q_valid,
    input  logic          q_ready,
    output dnd_pkg::req_t q_data
);

    dnd_pkg::req_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop     = q_valid && q_ready;
    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/dnd_walker.sv
// Name walker: message store, label and pointer walk, name buffer and result packing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dnd_walker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [dnd_pkg::POS_W-1:0] msg_len,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  dnd_pkg::req_t          q_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output dnd_pkg::out_item_t     m_data
);

    localparam int POS_W   = dnd_pkg::POS_W;
    localparam int TOT_W   = dnd_pkg::TOT_W;
    localparam int MSG_AW  = dnd_pkg::MSG_AW;
    localparam int NAME_AW = dnd_pkg::NAME_AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_CODE,
        S_PTR,
        S_LABEL,
        S_GREAD,
        S_GDATA,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [5:0]          rem_reg;
    logic [5:0]          hi_reg;
    logic [NAME_AW-1:0]  idx_reg;
    logic [2:0]          lane_reg;
    logic [63:0]         word_reg;
    dnd_pkg::out_item_t  out_reg;
    logic                m_valid_reg;

    logic [7:0] msg_mem [dnd_pkg::MESSAGE_DEPTH];
    logic [7:0] name_mem [dnd_pkg::MAX_NAME_LENGTH];
    logic [7:0] msg_rdata_reg;
    logic [7:0] name_rdata_reg;

    logic               pop;
    logic [POS_W-1:0]   off_ext;
    logic [POS_W-1:0]   msg_raddr;
    logic               msg_we;
    logic [NAME_AW-1:0] name_raddr;
    logic               name_we;
    logic [7:0]         name_wdata;

    logic [7:0]         c;
    logic [POS_W-1:0]   pos_p1;
    logic [TOT_W-1:0]   tot_p1;
    logic [POS_W-1:0]   lbl_end;
    logic               ovf_len;
    logic               ovf_lbl;
    logic               oob_lbl;
    logic [13:0]        target;
    logic               bad_ptr;
    logic [63:0]        word_ins;
    logic               word_done;
    logic               name_done;

    assign pop     = (state_reg == S_IDLE) && q_valid;
    assign q_ready = (state_reg == S_IDLE);
    assign off_ext = POS_W'(q_data.offset);

    assign c       = msg_rdata_reg;
    assign pos_p1  = pos_reg + POS_W'(1);
    assign tot_p1  = total_reg + TOT_W'(1);
    assign lbl_end = pos_p1 + POS_W'(c[5:0]);
    assign ovf_len = tot_p1 >= TOT_W'(dnd_pkg::MAX_NAME_LENGTH);
    assign ovf_lbl = ({1'b0, tot_p1} + (TOT_W + 1)'(c[5:0]))
                     >= (TOT_W + 1)'(dnd_pkg::MAX_NAME_LENGTH);
    assign oob_lbl = lbl_end > msg_len;
    assign target  = {hi_reg, msg_rdata_reg};
    assign bad_ptr = POS_W'(target) >= pos_reg;

    assign name_done = (TOT_W'(idx_reg) + TOT_W'(1)) == total_reg;
    assign word_done = name_done || (lane_reg == 3'd7);

    always_comb begin
        word_ins = word_reg;
        word_ins[lane_reg*8 +: 8] = name_rdata_reg;
    end

    // Memory address and write control follow the walk state.
    always_comb begin
        msg_raddr  = pos_reg;
        msg_we     = pop && (q_data.kind == dnd_pkg::REQ_LOAD);
        name_raddr = idx_reg;
        name_we    = 1'b0;
        name_wdata = c;
        case (state_reg)
            S_CODE: begin
                msg_raddr = pos_p1;
                if (c == 8'd0) begin
                    name_we    = 1'b1;
                    name_wdata = 8'd0;
                end else if (c[7:6] == 2'b00 && !ovf_len) begin
                    name_we = 1'b1;
                end
            end
            S_LABEL: begin
                msg_raddr = pos_p1;
                name_we   = 1'b1;
            end
            S_GDATA: begin
                name_raddr = idx_reg + NAME_AW'(1);
            end
            default: begin
                msg_raddr = pos_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (msg_we) begin
            msg_mem[off_ext[MSG_AW-1:0]] <= q_data.byte_value;
        end
        msg_rdata_reg <= msg_mem[msg_raddr[MSG_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (name_we) begin
            name_mem[total_reg[NAME_AW-1:0]] <= name_wdata;
        end
        name_rdata_reg <= name_mem[name_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            total_reg   <= '0;
            rem_reg     <= '0;
            hi_reg      <= '0;
            idx_reg     <= '0;
            lane_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (pop && q_data.kind == dnd_pkg::REQ_NAME) begin
                        pos_reg   <= off_ext;
                        total_reg <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (pos_reg >= msg_len) begin
                        out_reg     <= '{64'd0, 4'd0, 1'b1, dnd_pkg::ST_OOB, 8'd0};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_EMIT;
                    end else begin
                        state_reg <= S_CODE;
                    end
                end
                S_CODE: begin
                    if (c == 8'd0) begin
                        total_reg <= tot_p1;
                        idx_reg   <= '0;
                        lane_reg  <= '0;
                        word_reg  <= '0;
                        state_reg <= S_GREAD;
                    end else if (c[7:6] == 2'b11) begin
                        if (pos_p1 >= msg_len) begin
                            out_reg <= '{64'd0, 4'd0, 1'b1, dnd_pkg::ST_OOB, 8'd0};
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_EMIT;
                        end else begin
                            hi_reg    <= c[5:0];
                            state_reg <= S_PTR;
                        end
                    end else if (c[7:6] == 2'b00) begin
                        if (ovf_len || ovf_lbl) begin
                            out_reg <= '{64'd0, 4'd0, 1'b1, dnd_pkg::ST_OVERFLOW, 8'd0};
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_EMIT;
                        end else if (oob_lbl) begin
                            out_reg <= '{64'd0, 4'd0, 1'b1, dnd_pkg::ST_OOB, 8'd0};
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_EMIT;
                        end else begin
                            total_reg <= tot_p1;
                            pos_reg   <= pos_p1;
                            rem_reg   <= c[5:0];
                            state_reg <= S_LABEL;
                        end
                    end else begin
                        out_reg     <= '{64'd0, 4'd0, 1'b1, dnd_pkg::ST_BAD_LENGTH, 8'd0};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_EMIT;
                    end
                end
                S_PTR: begin
                    if (bad_ptr) begin
                        out_reg     <= '{64'd0, 4'd0, 1'b1, dnd_pkg::ST_BAD_POINTER, 8'd0};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_EMIT;
                    end else begin
                        pos_reg   <= POS_W'(target);
                        state_reg <= S_ISSUE;
                    end
                end
                S_LABEL: begin
                    total_reg <= tot_p1;
                    pos_reg   <= pos_p1;
                    rem_reg   <= rem_reg - 6'd1;
                    if (rem_reg == 6'd1) begin
                        state_reg <= S_ISSUE;
                    end
                end
                S_GREAD: begin
                    state_reg <= S_GDATA;
                end
                S_GDATA: begin
                    word_reg <= word_ins;
                    idx_reg  <= idx_reg + NAME_AW'(1);
                    lane_reg <= lane_reg + 3'd1;
                    if (word_done) begin
                        out_reg.name_bytes   <= word_ins;
                        out_reg.byte_count   <= {1'b0, lane_reg} + 4'd1;
                        out_reg.last         <= name_done;
                        out_reg.status       <= dnd_pkg::ST_OK;
                        out_reg.total_length <= name_done ? total_reg[7:0] : 8'd0;
                        m_valid_reg          <= 1'b1;
                        state_reg            <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (out_reg.last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            word_reg  <= '0;
                            lane_reg  <= '0;
                            state_reg <= S_GREAD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `DND_ASSERT_IMP(a_err_empty, m_valid_reg && out_reg.status != dnd_pkg::ST_OK,
                    out_reg.last && out_reg.byte_count == 4'd0)
    `DND_ASSERT_IMP(a_mid_full, m_valid_reg && !out_reg.last, out_reg.byte_count == 4'd8)
    `DND_ASSERT_IMP(a_ok_len, m_valid_reg && out_reg.last && out_reg.status == dnd_pkg::ST_OK,
                    out_reg.total_length != 8'd0)
    `DND_ASSERT(a_total_cap, total_reg <= TOT_W'(dnd_pkg::MAX_NAME_LENGTH))
    `DND_ASSERT_IMP(a_valid_emit, m_valid_reg, state_reg == S_EMIT)

endmodule

// File: rtl/dns_name_decompressor.sv
// Top level of the DNS name decompressor: config register, intake, queue and walker.
`timescale 1ns / 1ps

// Load requests (operation 0) write one byte into a 4096-byte message store
// and produce no result; a load is written when the walker takes it from the
// queue while idle. A decompress request (operation 1) walks the stored
// message from its offset, one store byte per cycle through a single read
// port: each length octet is read and checked, label bytes are copied into the
// name buffer, and a pointer hop reads its second octet and jumps. The name is
// then read back out of the name buffer and packed into 8-byte results, each
// held until m_ready takes it. Results carry up to eight name bytes each,
// lowest octet first; total_length is set on the last one. Any error gives a
// single result with last set and the status code. Write message_length
// through cfg_* only while idle. Intake keeps taking requests into a
// two-entry queue while the walker is busy or a result is stalled on m_ready.
// Reading a store byte never loaded is undefined.
module dns_name_decompressor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dnd_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dnd_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [12:0]         cfg_data
);

    logic [dnd_pkg::LEN_W-1:0] msg_len_reg;
    logic [dnd_pkg::POS_W-1:0] len_eff;
    logic                      q_full;
    logic                      q_push;
    dnd_pkg::req_t             q_entry;
    logic                      q_valid;
    logic                      q_ready;
    dnd_pkg::req_t             q_data;

    // Always take the register write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_len_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            msg_len_reg <= cfg_data;
        end
    end

    // Clamp the length to the store depth.
    assign len_eff = (dnd_pkg::POS_W'(msg_len_reg) > dnd_pkg::POS_W'(dnd_pkg::MESSAGE_DEPTH)) ?
                     dnd_pkg::POS_W'(dnd_pkg::MESSAGE_DEPTH) : dnd_pkg::POS_W'(msg_len_reg);

    dnd_front u_front (
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    dnd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data)
    );

    dnd_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .msg_len (len_eff),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: verif/dns_name_decompressor_tb.sv
// Self-checking testbench for the DNS name decompressor.
`timescale 1ns / 1ps

module dns_name_decompressor_tb;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 1000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    dnd_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    dnd_pkg::out_item_t m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [12:0]        cfg_data = '0;

    dns_name_decompressor DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state: a mirror of the message store and the length register.
    logic [7:0]  msg_mirror [dnd_pkg::MESSAGE_DEPTH];
    logic [12:0] msg_len_reg;
    dnd_pkg::out_item_t pending_words[$];

    int  fail_count;
    int  requests_sent;
    int  words_checked;
    int  error_words;
    int  idle_cycles;
    bit  hold_off;       // receiver forced stall
    bit  bursty_sender;

    // Walk the mirror from start and queue the expected result words.
    task automatic predict_name(input logic [11:0] start);
        logic [7:0] name_buf [dnd_pkg::MAX_NAME_LENGTH];
        int len, pos, total, c, target, n, cnt;
        logic [2:0] status;
        dnd_pkg::out_item_t w;
        len = (msg_len_reg < dnd_pkg::MESSAGE_DEPTH) ? msg_len_reg : dnd_pkg::MESSAGE_DEPTH;
        pos = start;
        total = 0;
        status = dnd_pkg::ST_OK;
        forever begin
            if (pos >= len) begin status = dnd_pkg::ST_OOB; break; end
            c = msg_mirror[pos];
            pos++;
            if (c == 0) break;
            if (c >= 192) begin
                if (pos >= len) begin status = dnd_pkg::ST_OOB; break; end
                target = ((c & 63) << 8) | msg_mirror[pos];
                if (target >= pos - 1) begin status = dnd_pkg::ST_BAD_POINTER; break; end
                pos = target;
            end else if (c <= 63) begin
                total++;
                if (total >= dnd_pkg::MAX_NAME_LENGTH) begin
                    status = dnd_pkg::ST_OVERFLOW;
                    break;
                end
                name_buf[total-1] = c[7:0];
                if (total + c >= dnd_pkg::MAX_NAME_LENGTH) begin
                    status = dnd_pkg::ST_OVERFLOW;
                    break;
                end
                if (pos + c > len) begin status = dnd_pkg::ST_OOB; break; end
                for (int i = 0; i < c; i++) name_buf[total+i] = msg_mirror[pos+i];
                total += c;
                pos += c;
            end else begin
                status = dnd_pkg::ST_BAD_LENGTH;
                break;
            end
        end
        if (status != dnd_pkg::ST_OK) begin
            w = '0;
            w.last = 1'b1;
            w.status = status;
            pending_words.push_back(w);
            return;
        end
        name_buf[total] = 8'd0;
        total++;
        n = (total + 7) / 8;
        for (int k = 0; k < n; k++) begin
            w = '0;
            cnt = (total - k*8 < 8) ? total - k*8 : 8;
            for (int i = 0; i < cnt; i++) w.name_bytes[8*i +: 8] = name_buf[k*8+i];
            w.byte_count = cnt[3:0];
            w.last = (k + 1 == n);
            w.status = dnd_pkg::ST_OK;
            w.total_length = w.last ? total[7:0] : 8'd0;
            pending_words.push_back(w);
        end
    endtask

    // Offer one request, hold it until accepted, then update the predictor.
    // Valid stays high into the next request unless a gap is taken here.
    task automatic send_request(input logic op, input logic [11:0] off,
                                input logic [7:0] value);
        s_valid <= 1'b1;
        s_data  <= '{operation: op, offset: off, byte_value: value};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        if (op == dnd_pkg::OP_LOAD) begin
            msg_mirror[off] = value;
        end else begin
            predict_name(off);
        end
        if (bursty_sender && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic load_byte(input int addr, input int value);
        send_request(dnd_pkg::OP_LOAD, addr[11:0], value[7:0]);
    endtask

    // Issue a decompress only when every byte it could read has been loaded.
    task automatic name_request(input int start);
        send_request(dnd_pkg::OP_NAME, start[11:0], 8'($urandom()));
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value[12:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        msg_len_reg = value[12:0];
        @(posedge aclk);
    endtask

    // Receiver: stall on a pattern of its own unless forced off.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 9) < 7) || (requests_sent % 64 > 48);
    end

    // Result checker: compare each accepted word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                fail_count++;
            end else begin
                automatic dnd_pkg::out_item_t exp_w = pending_words.pop_front();
                if (m_data.name_bytes !== exp_w.name_bytes ||
                    m_data.byte_count !== exp_w.byte_count ||
                    m_data.last !== exp_w.last ||
                    m_data.status !== exp_w.status ||
                    m_data.total_length !== exp_w.total_length) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_w, m_data);
                    fail_count++;
                end
                words_checked++;
                if (exp_w.status != dnd_pkg::ST_OK) error_words++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (aresetn && !hold_off)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Build a small compressed message at base and return the position just past it.
    // Layout: 3 'a' 'b' 'c' 0 | 2 'x' 'y' ptr->base
    task automatic build_chain(input int base, output int end_pos);
        int p;
        p = base;
        load_byte(p++, 3); load_byte(p++, 8'h61); load_byte(p++, 8'h62);
        load_byte(p++, 8'h63); load_byte(p++, 0);
        load_byte(p++, 2); load_byte(p++, 8'h78); load_byte(p++, 8'h79);
        load_byte(p++, 8'hC0 | (base >> 8)); load_byte(p++, base & 8'hFF);
        end_pos = p;
    endtask

    task automatic test_directed;
        int e;
        // Empty message: any start is out of bounds.
        write_length(0);
        load_byte(0, 0);
        name_request(0);
        write_length(4096);
        name_request(0);                 // root name
        build_chain(1, e);
        name_request(1);                 // plain label
        name_request(6);                 // label then backward pointer
        load_byte(e, 8'hC0); load_byte(e+1, e[7:0]);  // self pointer
        name_request(e);
        load_byte(e+2, 8'h40);           // bad length octet
        name_request(e+2);
        load_byte(e+3, 8'hBF);
        name_request(e+3);
        load_byte(e+4, 63);              // label runs past length
        write_length(e + 10);
        name_request(e+4);
        load_byte(4095, 8'hFF);
        load_byte(4094, 8'h00);
        write_length(4095);
        name_request(4094);
        name_request(4095);              // start past length
        write_length(8191);              // clamps to full depth
        name_request(4094);
        load_byte(4095, 8'hFF);
        name_request(4095);              // pointer whose second octet is past the end
    endtask

    // A long multi-word name and a pointer loop that must end in overflow.
    task automatic test_overflow;
        int base;
        base = 100;
        for (int l = 0; l < 2; l++) begin
            load_byte(base + l*64, 63);
            for (int i = 1; i < 64; i++) load_byte(base + l*64 + i, $urandom());
        end
        load_byte(base + 128, 0);
        name_request(base);              // 129 bytes: 17 results
        name_request(base + 64);         // 65 bytes: 9 results
        load_byte(base + 129, 2); load_byte(base + 130, 1); load_byte(base + 131, 2);
        load_byte(base + 132, 8'hC0 | ((base + 129) >> 8));
        load_byte(base + 133, (base + 129) & 8'hFF);
        name_request(base + 129);        // loops back on itself
    endtask

    // Random well-formed chains with random content, mixed with noise.
    task automatic test_random;
        int base, p, start, nlab, ll, prev, hi_off;
        write_length(4096);
        bursty_sender = 1'b1;
        for (int n = 0; n < 8; n++) begin
            base = 512 + n * 100;
            p = base;
            prev = -1;
            nlab = $urandom_range(1, 4);
            start = p;
            for (int j = 0; j < nlab; j++) begin
                ll = $urandom_range(0, 9);
                if (ll == 0) ll = 1;
                load_byte(p++, ll);
                for (int i = 0; i < ll; i++) load_byte(p++, $urandom());
            end
            if ($urandom_range(0, 1) && n > 0) begin
                prev = 512 + $urandom_range(0, n - 1) * 100;
                load_byte(p++, 8'hC0 | (prev >> 8));
                load_byte(p++, prev & 8'hFF);
            end else begin
                load_byte(p++, 0);
            end
            name_request(start);
            if ($urandom_range(0, 3) == 0) begin
                // broken: overwrite one byte, never the low pointer octet, with a
                // value that is not a valid length octet
                hi_off = (prev >= 0) ? p - start - 2 : p - start - 1;
                load_byte(start + $urandom_range(0, hi_off), $urandom_range(64, 191));
                name_request(start);
            end
        end
        bursty_sender = 1'b0;
    endtask

    // Stall the receiver long enough to back up the input, then drain.
    task automatic test_backpressure;
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 6; k++) name_request(512);
        join
        wait_drained();
    endtask

    initial begin
        fail_count = 0;
        requests_sent = 0;
        words_checked = 0;
        error_words = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        bursty_sender = 1'b0;
        msg_len_reg = '0;
        for (int i = 0; i < dnd_pkg::MESSAGE_DEPTH; i++) begin
            msg_mirror[i] = 8'd0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_random();
        test_backpressure();
        write_length(8191);
        write_length(0);
        wait_drained();
        $display("Sent %0d requests; checked %0d result words, %0d of them errors.",
                 requests_sent, words_checked, error_words);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/dnd_pkg.sv
rtl/dnd_front.sv
rtl/dnd_queue.sv
rtl/dnd_walker.sv
rtl/dns_name_decompressor.sv
verif/dns_name_decompressor_tb.sv
